/* rtl/assert_macros.svh */
// Assertion helpers included by text_console_writer.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/tcw_pkg.sv */
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int ROWS     = 25;
  localparam int COLS     = 80;
  localparam int CELLS    = ROWS * COLS;
  localparam int TAB_STEP = 8;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = 11;
  localparam int SUM_W  = ADDR_W + 1;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int STYLE_W = 3;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

  localparam logic [STYLE_W-1:0] STYLE_GRAY   = 3'd0;
  localparam logic [STYLE_W-1:0] STYLE_WHITE  = 3'd1;
  localparam logic [STYLE_W-1:0] STYLE_GREEN  = 3'd2;
  localparam logic [STYLE_W-1:0] STYLE_YELLOW = 3'd3;
  localparam logic [STYLE_W-1:0] STYLE_RED    = 3'd4;

  typedef logic [ADDR_W-1:0] addr_t;

  function automatic logic [ATTR_W-1:0] style_attr(input logic [STYLE_W-1:0] sel);
    logic [ATTR_W-1:0] a;
    case (sel)
      STYLE_WHITE:  a = 8'h0F;
      STYLE_GREEN:  a = 8'h02;
      STYLE_YELLOW: a = 8'h0E;
      STYLE_RED:    a = 8'h04;
      default:      a = 8'h07;
    endcase
    return a;
  endfunction

  // Store entry of screen cell (row, col); rows start on multiples of COLS.
  function automatic addr_t ring_addr(input addr_t base, input logic [ROW_W-1:0] row,
                                      input logic [COL_W-1:0] col);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(row) * SUM_W'(COLS);
    if (sum >= SUM_W'(CELLS)) sum = sum - SUM_W'(CELLS);
    sum = sum + SUM_W'(col);
    return ADDR_W'(sum);
  endfunction

  function automatic addr_t cursor_offset(input logic [ROW_W-1:0] row,
                                          input logic [COL_W-1:0] col);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(row) * SUM_W'(COLS) + SUM_W'(col);
    return ADDR_W'(sum);
  endfunction

endpackage

/* rtl/tcw_ram.sv */
`timescale 1ns / 1ps
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/text_console_writer.sv */
`timescale 1ns / 1ps
// Text console writer: a ROWS x COLS character console (80x25) whose cells live
// in one ring-addressed RAM with a single write port and a registered read.
// Each input item returns exactly one result item with the cursor after the
// command. A read waits for the registered RAM read before its result; a
// character that scrolls blanks the new bottom line one cell per cycle through
// the write port, and a clear screen blanks all CELLS cells the same way; no
// item is accepted while blanking runs. After reset a clearing pass zeroes
// the store, during which no item is accepted; the style register can be
// written at any time (cfg_ready is always high). The result of a scroll or
// clear is offered at once, and the blanking runs behind it.
`include "assert_macros.svh"
module text_console_writer (
  input  logic                          clk,
  input  logic                          rst_n,
  // command input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tcw_pkg::CMD_W-1:0]     in_cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcw_pkg::ROW_W-1:0]     in_read_row,
  input  logic [tcw_pkg::COL_W-1:0]     in_read_col,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcw_pkg::CHAR_W-1:0]    out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]    out_cell_attr,
  output logic [tcw_pkg::COL_W-1:0]     out_cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]     out_cursor_row,
  output logic [tcw_pkg::ADDR_W-1:0]    out_cursor_offset,
  output logic                          out_scrolled,
  // style register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcw_pkg::STYLE_W-1:0]   cfg_data
);
  import tcw_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [COL_W-1:0]    cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]    cur_row_r, cur_row_nxt;
  addr_t               base_r, base_nxt;
  logic [STYLE_W-1:0]  style_r;
  // blanking sweep: current entry, last entry, fill pattern
  addr_t               fill_addr_r, fill_addr_nxt;
  addr_t               fill_end_r, fill_end_nxt;
  logic [CELL_W-1:0]   fill_data_r, fill_data_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic [ATTR_W-1:0]   out_attr_r, out_attr_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic [ROW_W-1:0]    out_row_r, out_row_nxt;
  addr_t               out_off_r, out_off_nxt;
  logic                out_scr_r, out_scr_nxt;
  logic                out_load;

  logic                in_acc, out_free;
  logic [ATTR_W-1:0]   attr;
  logic [COL_W:0]      ncol;
  logic                wrap, printable, do_scroll, read_ok;
  logic [SUM_W-1:0]    base_sum;

  logic                ram_we;
  addr_t               ram_waddr, ram_raddr;
  logic [CELL_W-1:0]   ram_wdata, ram_rdata;

  tcw_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign attr      = style_attr(style_r);

  // A result can be taken on when the output register is empty or draining.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(state_r == ST_IDLE && out_free);
  assign in_acc   = in_valid && !in_stall;

  // put decode
  assign printable = !(in_char_code inside {CH_TAB, CH_LF, CH_CR});
  always_comb begin
    ncol = {1'b0, cur_col_r} + 1'b1;
    wrap = 1'b0;
    if (in_char_code == CH_TAB) begin
      ncol = ({1'b0, cur_col_r} | (COL_W+1)'(TAB_STEP - 1)) + 1'b1;
      wrap = ncol >= (COL_W+1)'(COLS);
    end else if (in_char_code inside {CH_LF, CH_CR}) begin
      wrap = 1'b1;
    end else begin
      wrap = ncol >= (COL_W+1)'(COLS);
    end
  end
  assign do_scroll = (in_cmd == CMD_PUT) && wrap && (cur_row_r == ROW_W'(ROWS - 1));
  assign read_ok   = (32'(in_read_row) < ROWS) && (32'(in_read_col) < COLS);
  assign base_sum  = SUM_W'(base_r) + SUM_W'(COLS);

  assign ram_raddr = ring_addr(base_r, in_read_row, in_read_col);

  always_comb begin
    if (state_r == ST_FILL) begin
      ram_we    = 1'b1;
      ram_waddr = fill_addr_r;
      ram_wdata = fill_data_r;
    end else begin
      ram_we    = in_acc && (in_cmd == CMD_PUT) && printable;
      ram_waddr = ring_addr(base_r, cur_row_r, cur_col_r);
      ram_wdata = {attr, in_char_code};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    base_nxt      = base_r;
    fill_addr_nxt = fill_addr_r;
    fill_end_nxt  = fill_end_r;
    fill_data_nxt = fill_data_r;
    out_load      = 1'b0;
    out_char_nxt  = out_char_r;
    out_attr_nxt  = out_attr_r;
    out_scr_nxt   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_load     = 1'b1;
          out_char_nxt = '0;
          out_attr_nxt = '0;
          case (in_cmd)
            CMD_PUT: begin
              if (wrap) begin
                cur_col_nxt = '0;
                if (do_scroll) begin
                  // new bottom row sits where the old top row was
                  out_scr_nxt   = 1'b1;
                  fill_addr_nxt = base_r;
                  fill_end_nxt  = ADDR_W'(SUM_W'(base_r) + SUM_W'(COLS - 1));
                  fill_data_nxt = {attr, CHAR_W'(0)};
                  base_nxt      = (base_sum >= SUM_W'(CELLS)) ?
                                  ADDR_W'(base_sum - SUM_W'(CELLS)) : ADDR_W'(base_sum);
                  state_nxt     = ST_FILL;
                end else begin
                  cur_row_nxt = cur_row_r + 1'b1;
                end
              end else begin
                cur_col_nxt = ncol[COL_W-1:0];
              end
            end
            CMD_READ: begin
              if (read_ok) begin
                out_load  = 1'b0;
                state_nxt = ST_READ;
              end
            end
            CMD_CLEAR: begin
              cur_col_nxt   = '0;
              cur_row_nxt   = '0;
              base_nxt      = '0;
              fill_addr_nxt = '0;
              fill_end_nxt  = ADDR_W'(CELLS - 1);
              fill_data_nxt = {attr, CHAR_W'(0)};
              state_nxt     = ST_FILL;
            end
            default: ;  // unused command: cursor only
          endcase
        end
      end
      ST_READ: begin
        out_load     = 1'b1;
        out_char_nxt = ram_rdata[CHAR_W-1:0];
        out_attr_nxt = ram_rdata[CELL_W-1:CHAR_W];
        state_nxt    = ST_IDLE;
      end
      ST_FILL: begin
        if (fill_addr_r == fill_end_r) state_nxt = ST_IDLE;
        else fill_addr_nxt = fill_addr_r + 1'b1;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_col_nxt = cur_col_nxt;
  assign out_row_nxt = cur_row_nxt;
  assign out_off_nxt = cursor_offset(cur_row_nxt, cur_col_nxt);

  always_comb begin
    if (out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // clearing pass after reset
      state_r     <= ST_FILL;
      fill_addr_r <= '0;
      fill_end_r  <= ADDR_W'(CELLS - 1);
      fill_data_r <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      base_r      <= '0;
      style_r     <= STYLE_GRAY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_end_r  <= fill_end_nxt;
      fill_data_r <= fill_data_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      base_r      <= base_nxt;
      if (cfg_valid && cfg_ready) style_r <= cfg_data;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char_r <= out_char_nxt;
      out_attr_r <= out_attr_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_off_r  <= out_off_nxt;
      out_scr_r  <= out_scr_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_char     = out_char_r;
  assign out_cell_attr     = out_attr_r;
  assign out_cursor_col    = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_offset = out_off_r;
  assign out_scrolled      = out_scr_r;

  `ASSERT_CLK(a_cursor_range, (32'(cur_row_r) < ROWS) && (32'(cur_col_r) < COLS), "cursor out of range")
  `ASSERT_CLK(a_base_range, 32'(base_r) < CELLS, "ring base out of range")
  `ASSERT_CLK(a_scroll_fill, in_acc && do_scroll |=> state_r == ST_FILL && out_valid_r && out_scrolled, "scroll did not start blanking")
  `ASSERT_NEVER(a_fill_past_end, state_r == ST_FILL && 32'(fill_addr_r) >= CELLS, "fill address past store")
endmodule

/* test/tb_text_console_writer.sv */
`timescale 1ns / 1ps
module tb_text_console_writer;
  import tcw_pkg::*;

  // cmd 3 is not decoded by the block; it only reports the cursor
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  // style codes 5..7 fall back to gray
  localparam logic [STYLE_W-1:0] STYLE_SPARE5 = 3'd5;
  localparam logic [STYLE_W-1:0] STYLE_SPARE6 = 3'd6;
  localparam logic [STYLE_W-1:0] STYLE_SPARE7 = 3'd7;

  // attribute byte per style code, black background throughout
  localparam logic [ATTR_W-1:0] ATTR_OF_STYLE [8] =
    '{8'h07, 8'h0F, 8'h02, 8'h0E, 8'h04, 8'h07, 8'h07, 8'h07};

  // a clear screen blanks CELLS cells behind its result; wait that out
  // before touching the style register and before the final verdict
  localparam int BLANK_TAIL   = CELLS + 64;
  localparam int RAND_ITEMS   = 1232;
  localparam int PHASES       = 8;
  localparam int LONG_HOLD    = 400;
  localparam int MAX_WAIT     = 10;

  typedef struct {
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [ADDR_W-1:0] cursor_offset;
    logic              scrolled;
  } console_view_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    int                reps;
    bit                typed;
    console_view_t     want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    in_cmd;
  logic [CHAR_W-1:0]   in_char_code;
  logic [ROW_W-1:0]    in_read_row;
  logic [COL_W-1:0]    in_read_col;

  logic                out_valid;
  logic                out_stall;
  logic [CHAR_W-1:0]   out_cell_char;
  logic [ATTR_W-1:0]   out_cell_attr;
  logic [COL_W-1:0]    out_cursor_col;
  logic [ROW_W-1:0]    out_cursor_row;
  logic [ADDR_W-1:0]   out_cursor_offset;
  logic                out_scrolled;

  logic                cfg_valid;
  logic                cfg_ready;
  logic [STYLE_W-1:0]  cfg_data;

  text_console_writer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_char_code      (in_char_code),
    .in_read_row       (in_read_row),
    .in_read_col       (in_read_col),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cell_char     (out_cell_char),
    .out_cell_attr     (out_cell_attr),
    .out_cursor_col    (out_cursor_col),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_offset (out_cursor_offset),
    .out_scrolled      (out_scrolled),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Console model: own copy of the cell ring, cursor, scroll base, style
  // ---------------------------------------------------------------------
  logic [CELL_W-1:0]  screen_cells [CELLS];
  int unsigned        pred_col;
  int unsigned        pred_row;
  int unsigned        scroll_base;
  logic [STYLE_W-1:0] style_sel;

  console_view_t pending_views [$];   // expected items, oldest first
  stim_row_t     directed_rows [$];
  int            mismatch_count  = 0;
  bit            idle_on         = 1'b1;  // random gaps/stalls enabled
  int            hold_off_cycles = 0;     // one-shot long stall request

  function automatic int unsigned screen_entry(int unsigned r, int unsigned c);
    return (scroll_base + r * COLS + c) % CELLS;
  endfunction

  // cursor to start of next line; past the bottom the ring base moves down
  // one line and the fresh bottom line is blanked with the current attribute
  function automatic bit start_line();
    int unsigned c;
    pred_col = 0;
    pred_row++;
    if (pred_row < ROWS) return 1'b0;
    pred_row    = ROWS - 1;
    scroll_base = (scroll_base + COLS) % CELLS;
    for (c = 0; c < COLS; c++)
      screen_cells[screen_entry(ROWS - 1, c)] = {ATTR_OF_STYLE[style_sel], 8'h00};
    return 1'b1;
  endfunction

  function automatic console_view_t console_step(logic [CMD_W-1:0] cmd,
                                                 logic [CHAR_W-1:0] ch,
                                                 logic [ROW_W-1:0] row,
                                                 logic [COL_W-1:0] col);
    console_view_t v;
    logic [CELL_W-1:0] entry_word;
    int unsigned i;
    v = '{default: '0};
    case (cmd)
      CMD_PUT: begin
        if (ch == CH_TAB) begin
          pred_col += TAB_STEP - (pred_col % TAB_STEP);
          if (pred_col >= COLS) v.scrolled = start_line();
        end else if (ch == CH_LF || ch == CH_CR) begin
          v.scrolled = start_line();
        end else begin
          screen_cells[screen_entry(pred_row, pred_col)] = {ATTR_OF_STYLE[style_sel], ch};
          pred_col++;
          if (pred_col >= COLS) v.scrolled = start_line();
        end
      end
      CMD_READ: begin
        // out-of-range reads return a blank cell and leave state alone
        if (row < ROWS && col < COLS) begin
          entry_word  = screen_cells[screen_entry(row, col)];
          v.cell_char = entry_word[CHAR_W-1:0];
          v.cell_attr = entry_word[CELL_W-1:CHAR_W];
        end
      end
      CMD_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen_cells[i] = {ATTR_OF_STYLE[style_sel], 8'h00};
        pred_col    = 0;
        pred_row    = 0;
        scroll_base = 0;
      end
      default: ;  // unused command: cursor report only
    endcase
    v.cursor_col    = COL_W'(pred_col);
    v.cursor_row    = ROW_W'(pred_row);
    v.cursor_offset = ADDR_W'(pred_row * COLS + pred_col);
    return v;
  endfunction

  function automatic console_view_t view(int ch, int attr, int col, int row, int off,
                                         bit scr);
    console_view_t v;
    v.cell_char     = CHAR_W'(ch);
    v.cell_attr     = ATTR_W'(attr);
    v.cursor_col    = COL_W'(col);
    v.cursor_row    = ROW_W'(row);
    v.cursor_offset = ADDR_W'(off);
    v.scrolled      = scr;
    return v;
  endfunction

  // directed row checked against the model, possibly repeated
  function automatic void directed_row(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                       logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                       int reps);
    stim_row_t s;
    s.cmd = cmd; s.ch = ch; s.row = row; s.col = col; s.reps = reps;
    s.typed = 1'b0;
    s.want  = '{default: '0};
    directed_rows.push_back(s);
  endfunction

  // directed row with the result written out by hand
  function automatic void directed_typed(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                         logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                         console_view_t want);
    stim_row_t s;
    s.cmd = cmd; s.ch = ch; s.row = row; s.col = col; s.reps = 1;
    s.typed = 1'b1;
    s.want  = want;
    directed_rows.push_back(s);
  endfunction

  // ---------------------------------------------------------------------
  // Command side. Entered and left at a falling edge; the gap comes first
  // so in_valid stays high across back-to-back items.
  // ---------------------------------------------------------------------
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                           logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           bit typed, console_view_t want);
    int unsigned gap;
    console_view_t predicted;
    gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_char_code <= ch;
    in_read_row  <= row;
    in_read_col  <= col;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = console_step(cmd, ch, row, col);
    if (typed) pending_views.push_back(want);
    else       pending_views.push_back(predicted);
    @(negedge clk);
  endtask

  // stop offering, let every result come back, then let any blanking
  // that runs behind a scroll or clear finish
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (BLANK_TAIL) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_style(logic [STYLE_W-1:0] sel);
    cfg_valid <= 1'b1;
    cfg_data  <= sel;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    style_sel = sel;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly printable text with line breaks and tabs so the screen fills
  // and scrolls; reads lean toward the cursor line where text just landed
  task automatic random_item(output logic [CMD_W-1:0] cmd, output logic [CHAR_W-1:0] ch,
                             output logic [ROW_W-1:0] row, output logic [COL_W-1:0] col);
    int unsigned sel;
    int unsigned pick;
    sel = $urandom_range(0, 999);
    ch  = CHAR_W'($urandom_range(0, 255));
    row = ROW_W'($urandom_range(0, 31));
    col = COL_W'($urandom_range(0, 127));
    if (sel < 10) begin
      cmd = CMD_CLEAR;
    end else if (sel < 30) begin
      cmd = CMD_NOP;
    end else if (sel < 280) begin
      cmd  = CMD_READ;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        if ($urandom_range(0, 1)) row = ROW_W'($urandom_range(ROWS, 31));
        else                      col = COL_W'($urandom_range(COLS, 127));
      end else if (pick < 5) begin
        row = ROW_W'(pred_row);
        col = COL_W'($urandom_range(0, pred_col));
      end else begin
        row = ROW_W'($urandom_range(0, ROWS - 1));
        col = COL_W'($urandom_range(0, COLS - 1));
      end
    end else begin
      cmd  = CMD_PUT;
      pick = $urandom_range(0, 99);
      if      (pick < 8)  ch = CH_LF;
      else if (pick < 12) ch = CH_CR;
      else if (pick < 20) ch = CH_TAB;
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic [STYLE_W-1:0] phase_style [PHASES];
    logic [CMD_W-1:0]   cmd;
    logic [CHAR_W-1:0]  ch;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    int                 per_phase;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_cmd       = CMD_PUT;
    in_char_code = '0;
    in_read_row  = '0;
    in_read_col  = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;

    foreach (screen_cells[i]) screen_cells[i] = '0;
    pred_col    = 0;
    pred_row    = 0;
    scroll_base = 0;
    style_sel   = STYLE_GRAY;

    phase_style = '{STYLE_WHITE, STYLE_GREEN, STYLE_YELLOW, STYLE_RED,
                    STYLE_SPARE7, STYLE_GRAY, STYLE_SPARE5, STYLE_SPARE6};

    // fresh store after reset: all cells zero, gray style
    directed_typed(CMD_READ, 8'h00, 5'd0,  7'd0,   view(0, 0, 0, 0, 0, 0));
    directed_typed(CMD_READ, 8'h00, 5'd24, 7'd79,  view(0, 0, 0, 0, 0, 0));
    directed_typed(CMD_READ, 8'h00, 5'd31, 7'd127, view(0, 0, 0, 0, 0, 0));
    directed_typed(CMD_NOP,  8'hFF, 5'd31, 7'd127, view(0, 0, 0, 0, 0, 0));
    directed_typed(CMD_PUT,  8'h41, 5'd0,  7'd0,   view(0, 0, 1, 0, 1, 0));
    directed_typed(CMD_PUT,  8'h00, 5'd0,  7'd0,   view(0, 0, 2, 0, 2, 0));
    directed_typed(CMD_PUT,  8'hFF, 5'd31, 7'd127, view(0, 0, 3, 0, 3, 0));
    directed_typed(CMD_READ, 8'h00, 5'd0,  7'd0,   view(8'h41, 8'h07, 3, 0, 3, 0));
    // tab from an odd column, then from an aligned one
    directed_typed(CMD_PUT,  CH_TAB, 5'd0, 7'd0,   view(0, 0, 8, 0, 8, 0));
    directed_typed(CMD_PUT,  CH_TAB, 5'd0, 7'd0,   view(0, 0, 16, 0, 16, 0));
    directed_typed(CMD_PUT,  CH_CR,  5'd0, 7'd0,   view(0, 0, 0, 1, 80, 0));
    directed_typed(CMD_PUT,  CH_LF,  5'd0, 7'd0,   view(0, 0, 0, 2, 160, 0));
    directed_typed(CMD_PUT,  8'h7E,  5'd0, 7'd0,   view(0, 0, 1, 2, 161, 0));
    directed_typed(CMD_READ, 8'h00,  5'd2, 7'd0,   view(8'h7E, 8'h07, 1, 2, 161, 0));
    directed_typed(CMD_READ, 8'h00,  5'd0, 7'd2,   view(8'hFF, 8'h07, 1, 2, 161, 0));
    // clear blanks with the current attribute and homes everything
    directed_typed(CMD_CLEAR, 8'h00, 5'd0,  7'd0,  view(0, 0, 0, 0, 0, 0));
    directed_typed(CMD_READ,  8'h00, 5'd24, 7'd79, view(0, 8'h07, 0, 0, 0, 0));
    // tab that runs off the end of the line wraps
    directed_row  (CMD_PUT, CH_TAB, 5'd0, 7'd0, 9);
    directed_typed(CMD_PUT, CH_TAB, 5'd0, 7'd0,   view(0, 0, 0, 1, 80, 0));
    // printable wrap at the last column
    directed_row  (CMD_PUT, 8'h78,  5'd0, 7'd0, 79);
    directed_typed(CMD_PUT, 8'h79,  5'd0, 7'd0,   view(0, 0, 0, 2, 160, 0));
    // walk to the bottom row, then scroll once
    directed_row  (CMD_PUT, CH_LF,  5'd0, 7'd0, 22);
    directed_typed(CMD_PUT, CH_LF,  5'd0, 7'd0,   view(0, 0, 0, 24, 1920, 1));
    directed_typed(CMD_READ, 8'h00, 5'd24, 7'd0,  view(0, 8'h07, 0, 24, 1920, 0));
    directed_row  (CMD_READ, 8'h00, 5'd0,  7'd0, 1);
    // fill the bottom line to the last cell, then wrap with a scroll
    directed_row  (CMD_PUT, 8'h7A,  5'd0, 7'd0, 79);
    directed_typed(CMD_PUT, 8'h7A,  5'd0, 7'd0,   view(0, 0, 0, 24, 1920, 1));
    // tab wrap on the bottom row also scrolls
    directed_row  (CMD_PUT, CH_TAB, 5'd0, 7'd0, 10);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // input stays stalled through the power-up clearing pass
    foreach (directed_rows[k])
      repeat (directed_rows[k].reps)
        send_item(directed_rows[k].cmd, directed_rows[k].ch, directed_rows[k].row,
                  directed_rows[k].col, directed_rows[k].typed, directed_rows[k].want);

    per_phase = RAND_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      // style only changes with nothing in flight
      drain_results();
      write_style(phase_style[p]);
      idle_on = (p % 3 != 2);
      for (int n = 0; n < per_phase; n++) begin
        // in the second phase the receiver goes quiet for a while midway; input must back up
        if (p == 1 && n == per_phase / 2) hold_off_cycles = LONG_HOLD;
        random_item(cmd, ch, row, col);
        send_item(cmd, ch, row, col, 1'b0, '{default: '0});
      end
    end

    drain_results();
    if (mismatch_count == 0) $display("DONE: 0 errors");
    else                     $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side: random stalls, compare against the oldest expectation
  // ---------------------------------------------------------------------
  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin : results
    int unsigned   wait_cycles;
    console_view_t want;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        wait_cycles     = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        wait_cycles = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_views.size() == 0) begin
        $error("result item with no command outstanding");
        mismatch_count++;
      end else begin
        want = pending_views.pop_front();
        check_field("cell_char",     16'(want.cell_char),     16'(out_cell_char));
        check_field("cell_attr",     16'(want.cell_attr),     16'(out_cell_attr));
        check_field("cursor_col",    16'(want.cursor_col),    16'(out_cursor_col));
        check_field("cursor_row",    16'(want.cursor_row),    16'(out_cursor_row));
        check_field("cursor_offset", 16'(want.cursor_offset), 16'(out_cursor_offset));
        check_field("scrolled",      16'(want.scrolled),      16'(out_scrolled));
      end
      @(negedge clk);
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/text_console_writer.sv
test/tb_text_console_writer.sv
